### rtl/lie_pkg.sv
// shared types, codes and constants for the lowest-id leader election block
package lie_pkg;

  // default table size and reset values
  localparam int          MAX_PEERS_DEF = 16;
  localparam logic [15:0] HYST_RESET    = 16'd5000;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST    = 1'd1;

  // event modes
  localparam logic [2:0] MODE_ONLINE  = 3'd0;
  localparam logic [2:0] MODE_OFFLINE = 3'd1;
  localparam logic [2:0] MODE_CLEAR   = 3'd2;
  localparam logic [2:0] MODE_ADD     = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // commands broadcast to the cells
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_ONLINE_HIT = 3'd1;
  localparam logic [2:0] CMD_NEW_FREE   = 3'd2;
  localparam logic [2:0] CMD_OFFLINE    = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;
  localparam logic [2:0] CMD_UNMARK_HIT = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] peer_id;
    logic [31:0] now_ms;
    logic        end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        changed;
    logic [63:0] server_id;
    logic [31:0] epoch;
    logic        is_server;
    logic        grace_pending;
  } out_item_t;

  // scan packet travelling down the row of cells
  typedef struct packed {
    logic [63:0] query;
    logic        hit;
    logic        hit_online;
    logic        hit_marked;
    logic [31:0] hit_stamp;
    logic        free_found;
    logic [63:0] min_key;
  } scan_pkt_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [31:0] stamp;
  } cell_cmd_t;

endpackage

### rtl/lie_cell.sv
// one peer table entry with its stage of the scan chain
module lie_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  lie_pkg::scan_pkt_t in_pkt,
  output logic               out_vld,
  output lie_pkg::scan_pkt_t out_pkt,
  input  lie_pkg::cell_cmd_t cmd
);

  logic [63:0]        key_r, key_nxt;
  logic [31:0]        stamp_r, stamp_nxt;
  logic               online_r, online_nxt;
  logic               marked_r, marked_nxt;
  logic               hit_here_r, hit_here_nxt;
  logic               free_here_r, free_here_nxt;
  logic               vld_r;
  lie_pkg::scan_pkt_t pkt_r, pkt_nxt;
  logic               in_use, match, take_hit, take_free;

  assign in_use    = online_r | marked_r;
  assign match     = in_use && (key_r == in_pkt.query);
  assign take_hit  = !in_pkt.hit && match;
  assign take_free = !in_pkt.free_found && !in_use;

  always_comb begin
    pkt_nxt = in_pkt;
    if (take_hit) begin
      pkt_nxt.hit        = 1'b1;
      pkt_nxt.hit_online = online_r;
      pkt_nxt.hit_marked = marked_r;
      pkt_nxt.hit_stamp  = stamp_r;
    end
    if (take_free) begin
      pkt_nxt.free_found = 1'b1;
    end
    if (online_r && (key_r < in_pkt.min_key)) begin
      pkt_nxt.min_key = key_r;
    end
  end

  assign hit_here_nxt  = in_vld ? take_hit  : hit_here_r;
  assign free_here_nxt = in_vld ? take_free : free_here_r;

  // table updates, addressed by the flags left by the last scan; a clear hits every cell
  always_comb begin
    key_nxt    = key_r;
    stamp_nxt  = stamp_r;
    online_nxt = online_r;
    marked_nxt = marked_r;
    case (cmd.op)
      lie_pkg::CMD_ONLINE_HIT: begin
        if (hit_here_r) online_nxt = 1'b1;
      end
      lie_pkg::CMD_NEW_FREE: begin
        if (free_here_r) begin
          key_nxt    = cmd.key;
          online_nxt = 1'b1;
          marked_nxt = 1'b0;
        end
      end
      lie_pkg::CMD_OFFLINE: begin
        if (hit_here_r) begin
          online_nxt = 1'b0;
          marked_nxt = 1'b1;
          stamp_nxt  = cmd.stamp;
        end
      end
      lie_pkg::CMD_CLEAR: begin
        online_nxt = 1'b0;
        marked_nxt = 1'b0;
      end
      lie_pkg::CMD_UNMARK_HIT: begin
        if (hit_here_r) marked_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= 1'b0;
      marked_r    <= 1'b0;
      hit_here_r  <= 1'b0;
      free_here_r <= 1'b0;
      vld_r       <= 1'b0;
    end else begin
      online_r    <= online_nxt;
      marked_r    <= marked_nxt;
      hit_here_r  <= hit_here_nxt;
      free_here_r <= free_here_nxt;
      vld_r       <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    stamp_r <= stamp_nxt;
    pkt_r   <= pkt_nxt;
  end

  assign out_vld = vld_r;
  assign out_pkt = pkt_r;

endmodule

### rtl/lowest_id_leader_election.sv
// top level of the lowest-id leader election block with its control sequencer
//
//   port group   direction   handshake          payload
//   in_*         input       in_valid/in_stall  lie_pkg::in_item_t
//   out_*        output      out_valid/out_stall lie_pkg::out_item_t
//   cfg_*        input       cfg_we             cfg_index, cfg_wdata
//
// an item needs a second scan only when it re-elects, and may wait for the output slot;
// each scan walks the whole row of cells, one cell a cycle
// reset (rst_n low at a clock edge) empties the table and forgets the server
// in_stall is high from acceptance until the result is moved into the output
// register; a result held by out_stall does not block the next item's scans
module lowest_id_leader_election #(
  parameter int MAX_PEERS = lie_pkg::MAX_PEERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lie_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lie_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [lie_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_wdata
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1; // lookup of peer_id and first free entry
  localparam logic [1:0] S_SCAN2 = 2'd2; // minimum search and lookup of the server
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                launch_r, launch_nxt;
  lie_pkg::in_item_t   item_r, item_nxt;

  // configuration
  logic [63:0]         self_id_r, self_id_nxt;
  logic [15:0]         hyst_r, hyst_nxt;

  // election state
  logic [63:0]         cur_r, cur_nxt;
  logic                srv_valid_r, srv_valid_nxt;
  logic [31:0]         epoch_r, epoch_nxt;
  logic                grace_r, grace_nxt;

  // per item result
  logic [1:0]          status_r, status_nxt;
  logic                changed_r, changed_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  lie_pkg::out_item_t  out_data_r, out_data_nxt;

  // scan chain
  logic                chain_vld [MAX_PEERS+1];
  lie_pkg::scan_pkt_t  chain_pkt [MAX_PEERS+1];
  lie_pkg::scan_pkt_t  tail;
  lie_pkg::cell_cmd_t  cmd;

  logic                in_acc;
  logic                slot_free;
  logic                do_elect;
  logic                is_self;
  logic                diff;
  logic                held;
  logic [31:0]         elapsed;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // head of the chain: a fresh packet, query chosen by the scan in progress
  always_comb begin
    chain_vld[0]            = launch_r;
    chain_pkt[0].query      = (state_r == S_SCAN2) ? cur_r : item_r.peer_id;
    chain_pkt[0].hit        = 1'b0;
    chain_pkt[0].hit_online = 1'b0;
    chain_pkt[0].hit_marked = 1'b0;
    chain_pkt[0].hit_stamp  = '0;
    chain_pkt[0].free_found = 1'b0;
    chain_pkt[0].min_key    = self_id_r;
  end

  for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
    lie_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (chain_vld[g]),
      .in_pkt  (chain_pkt[g]),
      .out_vld (chain_vld[g+1]),
      .out_pkt (chain_pkt[g+1]),
      .cmd     (cmd)
    );
  end

  assign tail    = chain_pkt[MAX_PEERS];
  assign is_self = (item_r.peer_id == self_id_r);

  // hysteresis check against the current server's offline stamp
  assign diff    = srv_valid_r && (tail.min_key != cur_r);
  assign elapsed = item_r.now_ms - tail.hit_stamp;
  assign held    = diff && tail.hit && tail.hit_marked && (elapsed < {16'd0, hyst_r});

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    srv_valid_nxt = srv_valid_r;
    epoch_nxt     = epoch_r;
    grace_nxt     = grace_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    do_elect      = 1'b0;
    cmd.op        = lie_pkg::CMD_NONE;
    cmd.key       = item_r.peer_id;
    cmd.stamp     = item_r.now_ms;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt    = in_data;
          status_nxt  = lie_pkg::ST_APPLIED;
          changed_nxt = 1'b0;
          launch_nxt  = 1'b1;
          state_nxt   = S_SCAN1;
        end
      end

      S_SCAN1: begin
        if (chain_vld[MAX_PEERS]) begin
          case (item_r.mode)
            lie_pkg::MODE_ONLINE, lie_pkg::MODE_ADD: begin
              if (is_self) begin
                status_nxt = lie_pkg::ST_IGNORED;
              end else if (tail.hit) begin
                if (tail.hit_online) begin
                  status_nxt = lie_pkg::ST_IGNORED;
                end else begin
                  cmd.op = lie_pkg::CMD_ONLINE_HIT;
                end
              end else if (tail.free_found) begin
                cmd.op = lie_pkg::CMD_NEW_FREE;
              end else begin
                status_nxt = lie_pkg::ST_FULL;
              end
              if (item_r.mode == lie_pkg::MODE_ONLINE) begin
                do_elect = (status_nxt == lie_pkg::ST_APPLIED);
              end else begin
                do_elect = (status_nxt != lie_pkg::ST_FULL) && item_r.end_of_set;
              end
            end
            lie_pkg::MODE_OFFLINE: begin
              if (tail.hit && tail.hit_online) begin
                cmd.op   = lie_pkg::CMD_OFFLINE;
                do_elect = 1'b1;
              end else begin
                status_nxt = lie_pkg::ST_IGNORED;
              end
            end
            lie_pkg::MODE_CLEAR: begin
              cmd.op    = lie_pkg::CMD_CLEAR;
              grace_nxt = 1'b0;
              do_elect  = item_r.end_of_set;
            end
            lie_pkg::MODE_TICK: begin
              do_elect = grace_r;
            end
            default: begin
              status_nxt = lie_pkg::ST_IGNORED;
            end
          endcase
          // table write lands at this edge, the second scan starts after it
          if (do_elect) begin
            launch_nxt = 1'b1;
            state_nxt  = S_SCAN2;
          end else begin
            state_nxt  = S_DONE;
          end
        end
      end

      S_SCAN2: begin
        if (chain_vld[MAX_PEERS]) begin
          if (held) begin
            grace_nxt = 1'b1;
          end else begin
            // switching away from an offline server drops its mark
            if (diff && tail.hit && tail.hit_marked) begin
              cmd.op = lie_pkg::CMD_UNMARK_HIT;
            end
            grace_nxt = 1'b0;
            if (!srv_valid_r || (tail.min_key != cur_r)) begin
              cur_nxt       = tail.min_key;
              srv_valid_nxt = 1'b1;
              epoch_nxt     = epoch_r + 32'd1;
              changed_nxt   = 1'b1;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register, loaded once the previous item has gone
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if ((state_r == S_DONE) && slot_free) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = status_r;
      out_data_nxt.changed        = changed_r;
      out_data_nxt.server_id      = srv_valid_r ? cur_r : 64'd0;
      out_data_nxt.epoch          = epoch_r;
      out_data_nxt.is_server      = srv_valid_r && (cur_r == self_id_r);
      out_data_nxt.grace_pending  = grace_r;
    end
  end

  // configuration writes
  always_comb begin
    self_id_nxt = self_id_r;
    hyst_nxt    = hyst_r;
    if (cfg_we) begin
      case (cfg_index)
        lie_pkg::CFG_SELF_ID: self_id_nxt = cfg_wdata;
        lie_pkg::CFG_HYST:    hyst_nxt    = cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      self_id_r   <= 64'd0;
      hyst_r      <= lie_pkg::HYST_RESET;
      cur_r       <= 64'd0;
      srv_valid_r <= 1'b0;
      epoch_r     <= 32'd0;
      grace_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      self_id_r   <= self_id_nxt;
      hyst_r      <= hyst_nxt;
      cur_r       <= cur_nxt;
      srv_valid_r <= srv_valid_nxt;
      epoch_r     <= epoch_nxt;
      grace_r     <= grace_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    changed_r  <= changed_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
